/* hdl/ffha_pkg.sv */
// ----------------------------------------------------------------------------
// ffha_pkg: shared types and constants for the first-fit heap allocator
// Request/response structs, sequencer states and boundary tag constants.
// ----------------------------------------------------------------------------
package ffha_pkg;

	localparam int DEF_HEAP_WORDS  = 16384;
	localparam int DEF_CHUNK_BYTES = 4096;

	localparam logic [31:0] ALLOC_BIT    = 32'h1;
	localparam logic [31:0] PROLOGUE_TAG = 32'h9;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_NULL = 2'd1;
	localparam logic [1:0] ST_OOM  = 2'd2;

	typedef struct packed {
		logic        req_type;
		logic [15:0] request_bytes;
		logic [15:0] block_addr;
	} req_t;

	typedef struct packed {
		logic [15:0] result_addr;
		logic [1:0]  status;
	} rsp_t;

	typedef struct packed {
		logic valid;
		rsp_t rsp;
	} fin_t;

	typedef enum logic [1:0] {
		MODE_INIT,
		MODE_ALLOC,
		MODE_FREE
	} mode_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_INIT1,
		S_INIT2,
		S_INIT3,
		S_A_RD,
		S_A_CHK,
		S_G_CHK,
		S_G_WH,
		S_G_WF,
		S_G_WE,
		S_F_RD,
		S_F_CHK,
		S_F_WH,
		S_F_WF,
		S_M_RDP,
		S_M_RDN,
		S_M_CHK,
		S_M_WH,
		S_M_WF,
		S_C_W0,
		S_C_W1,
		S_C_W2,
		S_C_W3
	} seq_state_t;

endpackage

/* hdl/ffha_mem.sv */
// ----------------------------------------------------------------------------
// ffha_mem: heap word memory
// Single port, one write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module ffha_mem import ffha_pkg::*; #(
	parameter int HEAP_WORDS = DEF_HEAP_WORDS,
	localparam int IW = $clog2(HEAP_WORDS)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [IW-1:0] idx,
	input  logic [31:0]   wdata,
	output logic [31:0]   rdata
);

	logic [31:0] mem [HEAP_WORDS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[idx] <= wdata;
		end
		rdata <= mem[idx];
	end

endmodule

/* hdl/ffha_seq.sv */
// ----------------------------------------------------------------------------
// ffha_seq: allocator sequencer
// Walks block tags, grows the break, coalesces and splits blocks through
// read-modify-write sequences on the heap memory.
// ----------------------------------------------------------------------------
module ffha_seq import ffha_pkg::*; #(
	parameter int HEAP_WORDS  = DEF_HEAP_WORDS,
	parameter int CHUNK_BYTES = DEF_CHUNK_BYTES,
	localparam int IW = $clog2(HEAP_WORDS)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  req_t          request,
	output logic          busy,
	output fin_t          fin,
	output logic          mem_we,
	output logic [IW-1:0] mem_idx,
	output logic [31:0]   mem_wdata,
	input  logic [31:0]   mem_rdata
);

	localparam int AW = IW + 3;
	localparam logic [31:0] HEAP_BYTES = 32'(HEAP_WORDS * 4);
	localparam logic [16:0] CHUNK17 = 17'(CHUNK_BYTES);

	seq_state_t state_q, state_d;
	mode_t      mode_q;

	logic [AW-1:0] bp_q, size_q, brk_q;
	logic [16:0]   asize_q;
	logic [15:0]   addr_q;
	logic [31:0]   prev_q;

	logic [AW-1:0] mem_addr;
	logic [AW-1:0] hdr_size, psize, asz, rem, first;
	logic          hdr_alloc, palloc, split, past_brk, hit, fits;
	logic [17:0]   asize_sum;
	logic [16:0]   asize_in, ext;
	logic [17:0]   gsize;
	logic [31:0]   bp_w;

	assign hdr_size  = {mem_rdata[AW-1:3], 3'b000};
	assign hdr_alloc = mem_rdata[0];
	assign psize     = {prev_q[AW-1:3], 3'b000};
	assign palloc    = prev_q[0];
	assign asz       = AW'(asize_q);
	assign rem       = size_q - asz;
	assign split     = rem >= AW'(16);
	assign first     = split ? asz : size_q;
	assign past_brk  = bp_q >= brk_q;
	assign bp_w      = 32'(bp_q);
	assign hit       = bp_w == 32'(addr_q);

	assign asize_sum = 18'(request.request_bytes) + 18'd15;
	assign asize_in  = (request.request_bytes <= 16'd8) ? 17'd16
	                 : {asize_sum[16:3], 3'b000};

	assign ext   = (asize_q > CHUNK17) ? asize_q : CHUNK17;
	// round the word count up to even
	assign gsize = {1'b0, ext[16:3], 3'b000} + (ext[2] ? 18'd8 : 18'd0);
	assign fits  = (32'(brk_q) + 32'(gsize)) <= HEAP_BYTES;

	assign busy    = state_q != S_IDLE;
	assign mem_idx = mem_addr[IW+1:2];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (request.req_type == REQ_FREE) state_d = S_F_RD;
					else if (request.request_bytes != 16'd0) state_d = S_A_RD;
				end
			end
			S_INIT1: state_d = S_INIT2;
			S_INIT2: state_d = S_INIT3;
			S_INIT3: state_d = S_G_CHK;
			S_A_RD:  state_d = past_brk ? S_G_CHK : S_A_CHK;
			S_A_CHK: begin
				if (hdr_size == '0) state_d = S_G_CHK;
				else if (!hdr_alloc && 32'(asize_q) <= 32'(hdr_size)) state_d = S_C_W0;
				else state_d = S_A_RD;
			end
			S_G_CHK: state_d = fits ? S_G_WH : S_IDLE;
			S_G_WH:  state_d = S_G_WF;
			S_G_WF:  state_d = S_G_WE;
			S_G_WE:  state_d = S_M_RDP;
			S_F_RD:  state_d = past_brk ? S_IDLE : S_F_CHK;
			S_F_CHK: begin
				if (hdr_size == '0) state_d = S_IDLE;
				else if (hit) state_d = hdr_alloc ? S_F_WH : S_IDLE;
				else state_d = S_F_RD;
			end
			S_F_WH:  state_d = S_F_WF;
			S_F_WF:  state_d = S_M_RDP;
			S_M_RDP: state_d = S_M_RDN;
			S_M_RDN: state_d = S_M_CHK;
			S_M_CHK: state_d = S_M_WH;
			S_M_WH:  state_d = S_M_WF;
			S_M_WF:  state_d = (mode_q == MODE_ALLOC) ? S_C_W0 : S_IDLE;
			S_C_W0:  state_d = S_C_W1;
			S_C_W1:  state_d = split ? S_C_W2 : S_IDLE;
			S_C_W2:  state_d = S_C_W3;
			S_C_W3:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs: memory access and finish
	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = bp_q - AW'(4);
		mem_wdata = 32'(size_q);
		fin       = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start && request.req_type == REQ_ALLOC
				    && request.request_bytes == 16'd0) begin
					fin.valid      = 1'b1;
					fin.rsp.status = ST_NULL;
				end
			end
			S_INIT1: begin
				mem_we    = 1'b1;
				mem_addr  = AW'(4);
				mem_wdata = PROLOGUE_TAG;
			end
			S_INIT2: begin
				mem_we    = 1'b1;
				mem_addr  = AW'(8);
				mem_wdata = PROLOGUE_TAG;
			end
			S_INIT3: begin
				mem_we    = 1'b1;
				mem_addr  = AW'(12);
				mem_wdata = ALLOC_BIT;
			end
			S_A_RD, S_A_CHK: ;
			S_G_CHK: begin
				if (!fits && mode_q == MODE_ALLOC) begin
					fin.valid      = 1'b1;
					fin.rsp.status = ST_OOM;
				end
			end
			S_G_WH, S_F_WH, S_M_WH: mem_we = 1'b1;
			S_G_WF, S_F_WF, S_M_WF: begin
				mem_we   = 1'b1;
				mem_addr = bp_q + size_q - AW'(8);
				if (state_q == S_M_WF && mode_q == MODE_FREE) begin
					fin.valid           = 1'b1;
					fin.rsp.result_addr = addr_q;
				end
			end
			S_G_WE: begin
				mem_we    = 1'b1;
				mem_addr  = bp_q + size_q - AW'(4);
				mem_wdata = ALLOC_BIT;
			end
			S_F_RD: begin
				if (past_brk) begin
					fin.valid           = 1'b1;
					fin.rsp.result_addr = addr_q;
				end
			end
			S_F_CHK: begin
				if (hdr_size == '0 || (hit && !hdr_alloc)) begin
					fin.valid           = 1'b1;
					fin.rsp.result_addr = addr_q;
				end
			end
			S_M_RDP: mem_addr = bp_q - AW'(8);
			S_M_RDN: mem_addr = bp_q + size_q - AW'(4);
			S_M_CHK: ;
			S_C_W0: begin
				mem_we    = 1'b1;
				mem_wdata = 32'(first) | ALLOC_BIT;
			end
			S_C_W1: begin
				mem_we    = 1'b1;
				mem_addr  = bp_q + first - AW'(8);
				mem_wdata = 32'(first) | ALLOC_BIT;
				if (!split) begin
					fin.valid           = 1'b1;
					fin.rsp.result_addr = bp_w[15:0];
				end
			end
			S_C_W2: begin
				mem_we    = 1'b1;
				mem_addr  = bp_q + asz - AW'(4);
				mem_wdata = 32'(rem);
			end
			S_C_W3: begin
				mem_we              = 1'b1;
				mem_addr            = bp_q + size_q - AW'(8);
				mem_wdata           = 32'(rem);
				fin.valid           = 1'b1;
				fin.rsp.result_addr = bp_w[15:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT1;
			mode_q  <= MODE_INIT;
			brk_q   <= AW'(16);
			asize_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_G_WE) brk_q <= bp_q + size_q;
			if (state_q == S_IDLE && start) begin
				mode_q  <= (request.req_type == REQ_FREE) ? MODE_FREE : MODE_ALLOC;
				asize_q <= asize_in;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				addr_q <= request.block_addr;
				bp_q   <= (request.req_type == REQ_FREE) ? AW'(16) : AW'(8);
			end
			S_A_CHK: begin
				size_q <= hdr_size;
				if (!(!hdr_alloc && 32'(asize_q) <= 32'(hdr_size))) bp_q <= bp_q + hdr_size;
			end
			S_G_CHK: begin
				bp_q   <= brk_q;
				size_q <= AW'(gsize);
			end
			S_F_CHK: begin
				size_q <= hdr_size;
				if (!hit) bp_q <= bp_q + hdr_size;
			end
			S_M_RDN: prev_q <= mem_rdata;
			S_M_CHK: begin
				if (palloc) begin
					if (!hdr_alloc) size_q <= size_q + hdr_size;
				end else begin
					size_q <= size_q + psize + (hdr_alloc ? '0 : hdr_size);
					bp_q   <= bp_q - psize;
				end
			end
			default: ;
		endcase
	end

endmodule

/* hdl/first_fit_heap_allocator_core.sv */
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_core: boundary-tag heap manager
// First-fit allocate and coalescing free over an implicit block list.
// ----------------------------------------------------------------------------
// Usage:
//   A request transfers at a clock edge with start high and busy low. The
//   request struct carries req_type (0 allocate, 1 free), request_bytes and
//   block_addr. Each request gives one response: done is high for exactly one
//   cycle, the first with busy low after the transfer, with result.result_addr
//   and result.status valid. The receiver cannot stall and must take it then.
//   The tag walk over the single-port heap memory takes each block visited as a
//   header read, then a check. A free either releases a block, finds that the
//   address names a free block, or matches no block. An allocate either takes
//   a block that fits, with or without a split, grows the break first and then
//   does the same, or runs out of memory. A zero-size allocate answers the next
//   cycle with busy staying low. One request is in flight at a time. During
//   reset and after it the block is busy while it writes the prologue, the
//   first free chunk and the epilogue into the heap memory.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_core import ffha_pkg::*; #(
	parameter int HEAP_WORDS  = DEF_HEAP_WORDS,
	parameter int CHUNK_BYTES = DEF_CHUNK_BYTES
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t request,
	output logic busy,
	output logic done,
	output rsp_t result
);

	localparam int IW = $clog2(HEAP_WORDS);

	fin_t          fin;
	logic          mem_we;
	logic [IW-1:0] mem_idx;
	logic [31:0]   mem_wdata, mem_rdata;
	logic          done_q;
	rsp_t          result_q;

	ffha_seq #(
		.HEAP_WORDS  (HEAP_WORDS),
		.CHUNK_BYTES (CHUNK_BYTES)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.request   (request),
		.busy      (busy),
		.fin       (fin),
		.mem_we    (mem_we),
		.mem_idx   (mem_idx),
		.mem_wdata (mem_wdata),
		.mem_rdata (mem_rdata)
	);

	ffha_mem #(
		.HEAP_WORDS (HEAP_WORDS)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.idx   (mem_idx),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// response register, one-cycle strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= fin.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fin.valid) result_q <= fin.rsp;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb: testbench for first_fit_heap_allocator_core
// Drives allocate and free requests, keeps a shadow copy of the boundary-tag
// heap to predict each response, and compares every response field by field.
// ----------------------------------------------------------------------------
module tb;
	import ffha_pkg::*;

	localparam int unsigned NWORDS   = DEF_HEAP_WORDS;
	localparam int unsigned CHUNK    = DEF_CHUNK_BYTES;
	localparam int          N_RANDOM = 1030;
	localparam int          WD_LIMIT = 200000;

	class heap_shadow;
		logic [31:0] words [NWORDS];
		int unsigned brk;
		rsp_t        pending_rsp [$];
		int          errors;

		function new();
			foreach (words[i]) words[i] = '0;
			errors = 0;
			brk = 16;
			wr(4, 32'h9);
			wr(8, 32'h9);
			wr(12, ALLOC_BIT);
			void'(grow(CHUNK));
		endfunction

		function logic [31:0] rd(int unsigned a);
			return (a / 4 < NWORDS) ? words[a / 4] : 32'h0;
		endfunction

		function void wr(int unsigned a, logic [31:0] v);
			if (a / 4 < NWORDS) words[a / 4] = v;
		endfunction

		function int unsigned bsize(int unsigned bp);
			return rd(bp - 4) & ~32'h7;
		endfunction

		function bit balloc(int unsigned bp);
			return (rd(bp - 4) & ALLOC_BIT) != 32'h0;
		endfunction

		function void tag(int unsigned bp, int unsigned sz, bit a);
			wr(bp - 4, sz | a);
			wr(bp + sz - 8, sz | a);
		endfunction

		function int unsigned merge(int unsigned bp);
			int unsigned sz, psz, nsz;
			bit pa, na;
			sz  = bsize(bp);
			pa  = (rd(bp - 8) & ALLOC_BIT) != 32'h0;
			psz = rd(bp - 8) & ~32'h7;
			na  = balloc(bp + sz);
			nsz = bsize(bp + sz);
			if (pa && na) return bp;
			if (pa) sz += nsz;
			else begin
				sz += psz;
				if (!na) sz += nsz;
				bp -= psz;
			end
			tag(bp, sz, 1'b0);
			return bp;
		endfunction

		function int unsigned grow(int unsigned bytes);
			int unsigned w, sz, bp;
			w = bytes / 4;
			if (w & 1) w++;
			sz = w * 4;
			if (longint'(brk) + sz > longint'(NWORDS) * 4) return 0;
			bp = brk;
			tag(bp, sz, 1'b0);
			wr(bp + sz - 4, ALLOC_BIT);
			brk += sz;
			return merge(bp);
		endfunction

		// compute the response of one request and update the shadow heap
		function rsp_t serve(req_t rq);
			rsp_t r;
			int unsigned bp, asz, csz;
			r = '0;
			if (rq.req_type == REQ_FREE) begin
				r.result_addr = rq.block_addr;
				r.status = ST_OK;
				bp = 16;
				while (bp < brk && bsize(bp) > 0 && bp != rq.block_addr) bp += bsize(bp);
				if (bp == rq.block_addr && bp < brk && bsize(bp) > 0 && balloc(bp)) begin
					tag(bp, bsize(bp), 1'b0);
					void'(merge(bp));
				end
			end else if (rq.request_bytes == 0) begin
				r.status = ST_NULL;
			end else begin
				asz = (rq.request_bytes <= 8) ? 16 : 8 * ((rq.request_bytes + 15) / 8);
				bp = 8;
				while (bp < brk && bsize(bp) > 0) begin
					if (!balloc(bp) && asz <= bsize(bp)) break;
					bp += bsize(bp);
				end
				if (!(bp < brk && bsize(bp) > 0)) bp = grow(asz > CHUNK ? asz : CHUNK);
				if (bp == 0) r.status = ST_OOM;
				else begin
					csz = bsize(bp);
					if (csz - asz >= 16) begin
						tag(bp, asz, 1'b1);
						tag(bp + asz, csz - asz, 1'b0);
					end else tag(bp, csz, 1'b1);
					r.result_addr = bp[15:0];
				end
			end
			return r;
		endfunction

		function rsp_t note_request(req_t rq);
			rsp_t r;
			r = serve(rq);
			pending_rsp.push_back(r);
			return r;
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			if (pending_rsp.size() == 0) begin
				$display("%0t: unexpected response addr=%h status=%0d", $time,
					got.result_addr, got.status);
				errors++;
				return;
			end
			want = pending_rsp.pop_front();
			if (got.result_addr !== want.result_addr) begin
				$display("%0t: result_addr expected %h actual %h", $time,
					want.result_addr, got.result_addr);
				errors++;
			end
			if (got.status !== want.status) begin
				$display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n, start, busy, done;
	req_t request;
	rsp_t result;
	heap_shadow shadow;
	logic [15:0] live [$];
	logic [15:0] freed [$];
	int idle_pct;
	int quiet = 0;

	first_fit_heap_allocator_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .request(request),
		.busy(busy), .done(done), .result(result)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// response checking and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) shadow.check_response(result);
			if (done || (start && !busy)) quiet <= 0;
			else quiet <= quiet + 1;
			if (quiet >= WD_LIMIT) begin
				$display("tb: FAIL");
				$finish;
			end
		end
	end

	// one transfer; raises start at a falling edge and holds it until accepted
	task automatic issue(req_t rq);
		rsp_t r;
		while ($urandom_range(99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		request = rq;
		do @(posedge clk); while (busy);
		r = shadow.note_request(rq);
		if (rq.req_type == REQ_ALLOC && r.status == ST_OK) live.push_back(r.result_addr);
		@(negedge clk);
	endtask

	task automatic do_alloc(int unsigned bytes);
		req_t rq;
		rq.req_type = REQ_ALLOC;
		rq.request_bytes = bytes[15:0];
		rq.block_addr = 16'($urandom);
		issue(rq);
	endtask

	task automatic do_free(logic [15:0] a);
		req_t rq;
		rq.req_type = REQ_FREE;
		rq.request_bytes = 16'($urandom);
		rq.block_addr = a;
		issue(rq);
	endtask

	// frees a live block chosen at random, or a random address when none is live
	task automatic free_live();
		int k;
		logic [15:0] a;
		if (live.size() == 0) begin
			do_free(16'($urandom));
			return;
		end
		k = $urandom_range(live.size() - 1);
		a = live[k];
		live.delete(k);
		freed.push_back(a);
		if (freed.size() > 64) void'(freed.pop_front());
		do_free(a);
	endtask

	initial begin
		int sel;
		shadow = new();
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		idle_pct = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// directed part
		do_alloc(0);
		do_alloc(1);
		do_alloc(8);
		do_alloc(9);
		do_alloc(16);
		do_alloc(65535);          // out of memory
		do_alloc(4000);           // takes the rest of the first chunk
		do_free(16'd8);           // prologue, ignored
		do_free(16'd0);
		do_free(16'hFFFF);
		do_free(live[1]);         // middle block, neighbors allocated
		do_free(live[0]);         // coalesce with next
		do_free(live[2]);         // coalesce with previous
		do_free(live[2]);         // double free
		do_alloc(24);
		do_alloc(32768);
		do_alloc(16384);
		do_alloc(30000);          // heap full
		while (live.size() > 0) free_live();
		do_alloc(4088);           // 4096-byte block split from the merged free block
		do_alloc(4081);
		free_live();
		free_live();
		do_alloc(0);
		do_alloc(0);

		for (int i = 0; i < N_RANDOM; i++) begin
			case (i * 4 / N_RANDOM)
				0: idle_pct = 0;
				1: idle_pct = 77;
				2: idle_pct = 0;
				default: idle_pct = 22;
			endcase
			sel = $urandom_range(99);
			if (sel < 3) do_alloc(0);
			else if (sel < 40) do_alloc($urandom_range(1, 128));
			else if (sel < 48) do_alloc($urandom_range(129, 4096));
			else if (sel < 52) do_alloc($urandom_range(4097, 65535));
			else if (sel < 90) free_live();
			else if (sel < 95 && freed.size() > 0)
				do_free(freed[$urandom_range(freed.size() - 1)]);
			else do_free(16'($urandom));
		end
		start = 1'b0;

		while (shadow.pending_rsp.size() > 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (shadow.errors == 0 && shadow.pending_rsp.size() == 0) $display("tb: PASS");
		else $display("tb: FAIL");
		$finish;
	end
endmodule
